// ----- rtl/core/tlp_pkg.sv -----
// Shared types and constants for the telnet line input parser.
// No dependencies; tlp_front, tlp_queue, tlp_back and the core top use it.
`default_nettype none

package tlp_pkg;

    localparam int LINE_MAX_DEF = 64;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [7:0] B_BS    = 8'd8;
    localparam logic [7:0] B_NL    = 8'd10;
    localparam logic [7:0] B_SPACE = 8'd32;
    localparam logic [7:0] B_TILDE = 8'd126;
    localparam logic [7:0] B_DEL   = 8'd127;
    localparam logic [7:0] B_IP    = 8'd244;
    localparam logic [7:0] B_AYT   = 8'd246;
    localparam logic [7:0] B_EC    = 8'd247;
    localparam logic [7:0] B_EL    = 8'd248;
    localparam logic [7:0] B_SB    = 8'd250;
    localparam logic [7:0] B_WILL  = 8'd251;
    localparam logic [7:0] B_WONT  = 8'd252;
    localparam logic [7:0] B_IAC   = 8'd255;
    localparam logic [7:0] OPT_NAWS = 8'd31;

    localparam logic [2:0] KIND_CHAR  = 3'd0;
    localparam logic [2:0] KIND_EMPTY = 3'd1;
    localparam logic [2:0] KIND_INTR  = 3'd2;
    localparam logic [2:0] KIND_AYT   = 3'd3;
    localparam logic [2:0] KIND_DONAWS = 3'd4;
    localparam logic [2:0] KIND_WSIZE = 3'd5;
    localparam logic [2:0] KIND_TRUNC = 3'd6;

    localparam logic [2:0] OP_APPEND  = 3'd0;
    localparam logic [2:0] OP_ERASE   = 3'd1;
    localparam logic [2:0] OP_CLEAR   = 3'd2;
    localparam logic [2:0] OP_NEWLINE = 3'd3;
    localparam logic [2:0] OP_EVENT   = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [15:0] w;
        logic [15:0] h;
    } t_cmd;

endpackage

`default_nettype wire

// ----- rtl/core/tlp_if.sv -----
// Valid/ready channel interfaces for received bytes and results.
// Depends on nothing.
`default_nettype none

interface tlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface tlp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] window_width;
    logic [15:0] window_height;
    logic        last;
    modport source (output valid, output kind, output data_byte, output window_width,
                    output window_height, output last, input ready);
    modport sink (input valid, input kind, input data_byte, input window_width,
                  input window_height, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tlp_front.sv -----
// Front end: telnet command parser that turns received bytes into line commands.
// Depends on tlp_pkg and tlp_in_if.
`default_nettype none

module tlp_front (
    input  wire          i_clk,
    input  wire          i_rst_n,
    tlp_in_if.sink       i_rx,
    input  wire          i_q_full,
    output logic         o_push,
    output tlp_pkg::t_cmd o_cmd
);

    localparam logic [3:0] M_NORMAL = 4'd0;
    localparam logic [3:0] M_IAC    = 4'd1;
    localparam logic [3:0] M_WILL   = 4'd2;
    localparam logic [3:0] M_WONT   = 4'd3;
    localparam logic [3:0] M_SB     = 4'd4;
    localparam logic [3:0] M_WHI    = 4'd5;
    localparam logic [3:0] M_WLO    = 4'd6;
    localparam logic [3:0] M_HHI    = 4'd7;
    localparam logic [3:0] M_HLO    = 4'd8;
    localparam logic [3:0] M_END1   = 4'd9;
    localparam logic [3:0] M_END2   = 4'd10;

    logic [3:0]  r_mode, n_mode;
    logic        r_naws, n_naws;
    logic [15:0] r_wp, n_wp;
    logic [15:0] r_hp, n_hp;
    logic        acc;
    logic        cmd_v;
    logic [7:0]  b;

    assign i_rx.ready = !i_q_full;
    assign acc = i_rx.valid && !i_q_full;
    assign b = i_rx.rx_byte;
    assign o_push = acc && cmd_v;

    always_comb begin
        n_mode = r_mode;
        n_naws = r_naws;
        n_wp = r_wp;
        n_hp = r_hp;
        cmd_v = 1'b0;
        o_cmd = '0;
        case (r_mode)
            M_IAC: begin
                n_mode = M_NORMAL;
                if (b == tlp_pkg::B_IP) begin
                    cmd_v = 1'b1;
                    o_cmd.op = tlp_pkg::OP_EVENT;
                    o_cmd.kind = tlp_pkg::KIND_INTR;
                end else if (b == tlp_pkg::B_AYT) begin
                    cmd_v = 1'b1;
                    o_cmd.op = tlp_pkg::OP_EVENT;
                    o_cmd.kind = tlp_pkg::KIND_AYT;
                end else if (b == tlp_pkg::B_EC) begin
                    cmd_v = 1'b1;
                    o_cmd.op = tlp_pkg::OP_ERASE;
                end else if (b == tlp_pkg::B_EL) begin
                    cmd_v = 1'b1;
                    o_cmd.op = tlp_pkg::OP_CLEAR;
                end else if (b == tlp_pkg::B_WILL) begin
                    n_mode = M_WILL;
                end else if (b == tlp_pkg::B_WONT) begin
                    n_mode = M_WONT;
                end else if (b == tlp_pkg::B_SB) begin
                    n_mode = M_SB;
                end
            end
            M_WILL: begin
                n_mode = M_NORMAL;
                if (b == tlp_pkg::OPT_NAWS && !r_naws) begin
                    n_naws = 1'b1;
                    cmd_v = 1'b1;
                    o_cmd.op = tlp_pkg::OP_EVENT;
                    o_cmd.kind = tlp_pkg::KIND_DONAWS;
                end
            end
            M_WONT: begin
                n_mode = M_NORMAL;
                if (b == tlp_pkg::OPT_NAWS) begin
                    n_naws = 1'b0;
                end
            end
            M_SB: begin
                n_mode = (b == tlp_pkg::OPT_NAWS && r_naws) ? M_WHI : M_NORMAL;
            end
            M_WHI: begin
                n_wp = {b, 8'h00};
                n_mode = M_WLO;
            end
            M_WLO: begin
                n_wp = {r_wp[15:8], b};
                n_mode = M_HHI;
            end
            M_HHI: begin
                n_hp = {b, 8'h00};
                n_mode = M_HLO;
            end
            M_HLO: begin
                n_hp = {r_hp[15:8], b};
                n_mode = M_END1;
            end
            M_END1: begin
                n_mode = M_END2;
            end
            M_END2: begin
                n_mode = M_NORMAL;
                cmd_v = 1'b1;
                o_cmd.op = tlp_pkg::OP_EVENT;
                o_cmd.kind = tlp_pkg::KIND_WSIZE;
                o_cmd.w = r_wp;
                o_cmd.h = r_hp;
            end
            default: begin
                n_mode = M_NORMAL;
                if (b == tlp_pkg::B_IAC) begin
                    n_mode = M_IAC;
                end else if (b == tlp_pkg::B_NL) begin
                    cmd_v = 1'b1;
                    o_cmd.op = tlp_pkg::OP_NEWLINE;
                end else if (b inside {tlp_pkg::B_BS, tlp_pkg::B_DEL}) begin
                    cmd_v = 1'b1;
                    o_cmd.op = tlp_pkg::OP_ERASE;
                end else if (b inside {[tlp_pkg::B_SPACE:tlp_pkg::B_TILDE]}) begin
                    cmd_v = 1'b1;
                    o_cmd.op = tlp_pkg::OP_APPEND;
                    o_cmd.data = b;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_naws <= 1'b0;
            r_wp <= '0;
            r_hp <= '0;
        end else if (acc) begin
            r_mode <= n_mode;
            r_naws <= n_naws;
            r_wp <= n_wp;
            r_hp <= n_hp;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tlp_queue.sv -----
// Short command queue between the parser front end and the line back end.
// Depends on tlp_pkg.
`default_nettype none

module tlp_queue (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  tlp_pkg::t_cmd i_cmd,
    input  wire           i_pop,
    output logic          o_full,
    output logic          o_empty,
    output tlp_pkg::t_cmd o_cmd
);

    localparam int PW = $clog2(tlp_pkg::QUEUE_DEPTH);
    localparam int CW = PW + 1;

    tlp_pkg::t_cmd r_slot [tlp_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full = (r_cnt == CW'(tlp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;
    assign o_cmd = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tlp_back.sv -----
// Back end: line store, line editing and result output register.
// Depends on tlp_pkg and tlp_out_if.
`default_nettype none

module tlp_back #(
    parameter int LINE_MAX = tlp_pkg::LINE_MAX_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_q_empty,
    input  tlp_pkg::t_cmd i_cmd,
    output logic          o_pop,
    tlp_out_if.source     o_res
);

    localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int LW = AW + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SEND = 2'd2;

    logic [7:0]    r_mem [LINE_MAX];
    logic [7:0]    r_rd_data;
    logic [1:0]    r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic          r_trunc, n_trunc;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_ov, n_ov;
    logic [2:0]    r_kind, n_kind;
    logic [7:0]    r_data, n_data;
    logic [15:0]   r_w, n_w;
    logic [15:0]   r_h, n_h;
    logic          r_last, n_last;
    logic          out_free;
    logic          we;
    logic          at_end;

    assign out_free = !r_ov || o_res.ready;
    assign o_pop = (r_state == S_IDLE) && !i_q_empty && out_free;
    assign at_end = ({1'b0, r_idx} + 1'b1) == r_len;

    assign o_res.valid = r_ov;
    assign o_res.kind = r_kind;
    assign o_res.data_byte = r_data;
    assign o_res.window_width = r_w;
    assign o_res.window_height = r_h;
    assign o_res.last = r_last;

    always_comb begin
        n_state = r_state;
        n_len = r_len;
        n_trunc = r_trunc;
        n_idx = r_idx;
        n_ov = r_ov && !o_res.ready;
        n_kind = r_kind;
        n_data = r_data;
        n_w = r_w;
        n_h = r_h;
        n_last = r_last;
        we = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    case (i_cmd.op)
                        tlp_pkg::OP_APPEND: begin
                            if (r_len < LW'(LINE_MAX)) begin
                                we = 1'b1;
                                n_len = r_len + 1'b1;
                            end else if (!r_trunc) begin
                                n_trunc = 1'b1;
                                n_ov = 1'b1;
                                n_kind = tlp_pkg::KIND_TRUNC;
                                n_data = '0;
                                n_w = '0;
                                n_h = '0;
                                n_last = 1'b1;
                            end
                        end
                        tlp_pkg::OP_ERASE: begin
                            if (r_len != '0) begin
                                n_len = r_len - 1'b1;
                            end
                        end
                        tlp_pkg::OP_CLEAR: begin
                            n_len = '0;
                        end
                        tlp_pkg::OP_NEWLINE: begin
                            n_trunc = 1'b0;
                            if (r_len == '0) begin
                                n_ov = 1'b1;
                                n_kind = tlp_pkg::KIND_EMPTY;
                                n_data = '0;
                                n_w = '0;
                                n_h = '0;
                                n_last = 1'b1;
                            end else begin
                                n_idx = '0;
                                n_state = S_READ;
                            end
                        end
                        tlp_pkg::OP_EVENT: begin
                            n_ov = 1'b1;
                            n_kind = i_cmd.kind;
                            n_data = '0;
                            n_w = i_cmd.w;
                            n_h = i_cmd.h;
                            n_last = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_kind = tlp_pkg::KIND_CHAR;
                    n_data = r_rd_data;
                    n_w = '0;
                    n_h = '0;
                    n_last = at_end;
                    if (at_end) begin
                        n_len = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_len[AW-1:0]] <= i_cmd.data;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_data <= n_data;
        r_w <= n_w;
        r_h <= n_h;
        r_last <= n_last;
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len <= '0;
            r_trunc <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len <= n_len;
            r_trunc <= n_trunc;
            r_ov <= n_ov;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/telnet_line_input_parser_core.sv -----
// Telnet receive parser with line editing: the front end parses telnet
// commands into line commands that a four-entry queue hands to the back end,
// which keeps the line store and drives results. A byte is taken in each
// cycle while the queue has room. The back end retires one command per cycle
// when its output register is free; a newline with N stored characters holds
// it for one line-store read and one output load per character, in turn.
// Depends on tlp_pkg, tlp_if, tlp_front, tlp_queue and tlp_back.
`default_nettype none

module telnet_line_input_parser_core #(
    parameter int LINE_MAX = tlp_pkg::LINE_MAX_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    tlp_in_if.sink    i_rx,
    tlp_out_if.source o_res
);

    logic          q_full;
    logic          q_empty;
    logic          push;
    logic          pop;
    tlp_pkg::t_cmd push_cmd;
    tlp_pkg::t_cmd head_cmd;

    tlp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    tlp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    tlp_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire
